>>> hdl/i2rt_pkg.sv
package i2rt_pkg;

   localparam int MAX_DIGITS_DEF    = 32;
   localparam int ALPHABET_CAP_DEF  = 64;
   localparam int NUM_CSR           = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int NUMBER_W          = 32;
   localparam int CHAR_W            = 8;
   localparam int SYMBOL_W          = 6;
   localparam int NUM_SYMBOLS       = 64;
   localparam int DIV_STEPS         = 32;
   localparam int DIV_STEP_W        = 5;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DIV_STEP,
      ST_DIV_PUSH,
      ST_SIGN,
      ST_DIG_RD,
      ST_ALPHA_RD,
      ST_CHAR_LOAD
   } state_type;

   typedef struct packed {
      logic take_input;
      logic scan_start;
      logic scan_read;
      logic scan_check;
      logic div_start;
      logic div_step;
      logic digit_push;
      logic sign_load;
      logic digit_read;
      logic alpha_read;
      logic char_load;
   } cmd_type;

   typedef struct packed {
      logic scan_stop;
      logic scan_good;
      logic div_last;
      logic div_more;
      logic digit_last;
      logic negative;
      logic out_free;
   } status_type;

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LC_A && c <= CHAR_LC_Z) ||
             (c >= CHAR_UC_A && c <= CHAR_UC_Z);
   endfunction

   // dense code for an alphanumeric byte, 0..61
   function automatic logic [SYMBOL_W-1:0] symbol_code(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = c - CHAR_0;
      if (c >= CHAR_LC_A) begin
         d = c - CHAR_LC_A + 8'd10;
      end else if (c >= CHAR_UC_A) begin
         d = c - CHAR_UC_A + 8'd36;
      end
      return d[SYMBOL_W-1:0];
   endfunction

endpackage

>>> hdl/integer_to_radix_text.sv
// channel  direction  signals                                   beat
// req      in         req_valid, req_ready, req_number          one signed integer
// rsp      out        rsp_valid, rsp_ready, rsp_character,      one text character
//                     rsp_final_char
// csr      in         csr_we, csr_index, csr_wdata              one alphabet register
//
// per number: alphabet scan, read and check per character, up to ALPHABET_CAPACITY
// characters; one pass of the one-bit-a-cycle divider per digit; then digit read,
// alphabet read and character load per character out, plus a sign if negative
// the next number is taken once the last character sits in the output register
// synchronous active-high reset clears the state machine, output valid and alphabet
// a stalled rsp side holds the controller in its sign or character load state
module integer_to_radix_text #(
   parameter int MAX_DIGITS        = i2rt_pkg::MAX_DIGITS_DEF,
   parameter int ALPHABET_CAPACITY = i2rt_pkg::ALPHABET_CAP_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [i2rt_pkg::NUMBER_W-1:0] req_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [i2rt_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                 rsp_final_char,
   input  logic                                 csr_we,
   input  logic [i2rt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [i2rt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import i2rt_pkg::*;

   cmd_type    cmd;
   status_type status;

   i2rt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2rt_dpath #(
      .MAX_DIGITS        (MAX_DIGITS),
      .ALPHABET_CAPACITY (ALPHABET_CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_number     (req_number),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_character  (rsp_character),
      .rsp_final_char (rsp_final_char)
   );

endmodule

>>> hdl/i2rt_ctrl.sv
module i2rt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2rt_pkg::status_type status,
   output i2rt_pkg::cmd_type    cmd
);
   import i2rt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_input = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
            if (status.scan_stop) begin
               if (status.scan_good) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV_STEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_PUSH;
            end
         end
         ST_DIV_PUSH: begin
            cmd.digit_push = 1'b1;
            if (status.div_more) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_STEP;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIG_RD;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.sign_load = 1'b1;
               state_in      = ST_DIG_RD;
            end
         end
         ST_DIG_RD: begin
            cmd.digit_read = 1'b1;
            state_in       = ST_ALPHA_RD;
         end
         ST_ALPHA_RD: begin
            cmd.alpha_read = 1'b1;
            state_in       = ST_CHAR_LOAD;
         end
         ST_CHAR_LOAD: begin
            if (status.out_free) begin
               cmd.char_load = 1'b1;
               state_in      = status.digit_last ? ST_IDLE : ST_DIG_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/i2rt_dpath.sv
module i2rt_dpath #(
   parameter int MAX_DIGITS        = i2rt_pkg::MAX_DIGITS_DEF,
   parameter int ALPHABET_CAPACITY = i2rt_pkg::ALPHABET_CAP_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [i2rt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [i2rt_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [i2rt_pkg::NUMBER_W-1:0]   req_number,
   input  i2rt_pkg::cmd_type                      cmd,
   output i2rt_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [i2rt_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                   rsp_final_char
);
   import i2rt_pkg::*;

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);
   localparam int PW = $clog2(ALPHABET_CAPACITY + 1);

   logic [CSR_DATA_W-1:0] alpha_ff [NUM_CSR];
   logic [CSR_DATA_W-1:0] row_ff;
   logic [NUM_SYMBOLS-1:0] seen_ff;
   logic [PW-1:0]         pos_ff;
   logic [SYMBOL_W:0]     radix_ff;
   logic                  neg_ff;
   logic [NUMBER_W-1:0]   mag_ff;
   logic [SYMBOL_W-1:0]   rem_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [CW-1:0]         cnt_ff;
   logic [SYMBOL_W-1:0]   store_mem [MAX_DIGITS];
   logic [SYMBOL_W-1:0]   dig_ff;
   logic                  last_ff;
   logic                  out_valid_ff;
   logic [CHAR_W-1:0]     out_char_ff;
   logic                  out_final_ff;

   logic [5:0]            scan_addr;
   logic [CHAR_W-1:0]     scan_char;
   logic                  scan_alnum;
   logic [SYMBOL_W-1:0]   scan_code;
   logic                  scan_dup;
   logic [PW-1:0]         pos_in;
   logic [SYMBOL_W:0]     trial;
   logic                  trial_ge;
   logic [CW:0]           cnt_next;
   logic [CW-1:0]         cnt_prev;
   logic                  out_free;

   assign scan_addr  = 6'(pos_ff);
   assign scan_char  = row_ff[{scan_addr[2:0], 3'b000} +: CHAR_W];
   assign scan_alnum = is_alnum(scan_char);
   assign scan_code  = symbol_code(scan_char);
   assign scan_dup   = scan_alnum && seen_ff[scan_code];
   assign pos_in     = pos_ff + 1'b1;

   assign trial    = {rem_ff, mag_ff[NUMBER_W-1]};
   assign trial_ge = trial >= radix_ff;
   assign cnt_next = {1'b0, cnt_ff} + 1'b1;
   assign cnt_prev = cnt_ff - 1'b1;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      status            = '0;
      status.scan_stop  = (scan_char == CHAR_NUL) || !scan_alnum || scan_dup ||
                          (pos_in == PW'(ALPHABET_CAPACITY));
      status.scan_good  = (scan_char == CHAR_NUL) ? (pos_ff >= PW'(2))
                                                  : (scan_alnum && !scan_dup);
      status.div_last   = step_ff == DIV_STEP_W'(DIV_STEPS - 1);
      status.div_more   = (mag_ff != '0) && (cnt_next < (CW + 1)'(MAX_DIGITS));
      status.digit_last = last_ff;
      status.negative   = neg_ff;
      status.out_free   = out_free;
   end

   // alphabet registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            alpha_ff[i] <= '0;
         end
      end else if (csr_we) begin
         alpha_ff[csr_index] <= csr_wdata;
      end
   end

   // alphabet scan and row fetch
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         pos_ff  <= '0;
         seen_ff <= '0;
      end
      if (cmd.scan_read) begin
         row_ff <= alpha_ff[scan_addr[5:3]];
      end
      if (cmd.alpha_read) begin
         row_ff <= alpha_ff[dig_ff[5:3]];
      end
      if (cmd.scan_check) begin
         pos_ff <= pos_in;
         if (scan_alnum) begin
            seen_ff[scan_code] <= 1'b1;
         end
         radix_ff <= (scan_char == CHAR_NUL) ? (SYMBOL_W + 1)'(pos_ff)
                                             : (SYMBOL_W + 1)'(pos_in);
      end
   end

   // bit-serial restoring division and digit store
   always_ff @(posedge clock) begin
      if (cmd.take_input) begin
         neg_ff <= req_number[NUMBER_W-1];
         mag_ff <= req_number[NUMBER_W-1] ? (~req_number + 1'b1) : req_number;
         cnt_ff <= '0;
      end
      if (cmd.div_start) begin
         step_ff <= '0;
         rem_ff  <= '0;
      end
      if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
         rem_ff  <= trial_ge ? SYMBOL_W'(trial - radix_ff) : trial[SYMBOL_W-1:0];
         mag_ff  <= {mag_ff[NUMBER_W-2:0], trial_ge};
      end
      if (cmd.digit_push) begin
         store_mem[cnt_ff[AW-1:0]] <= rem_ff;
         cnt_ff                    <= cnt_next[CW-1:0];
      end
      if (cmd.digit_read) begin
         dig_ff  <= store_mem[cnt_prev[AW-1:0]];
         last_ff <= cnt_ff == CW'(1);
         cnt_ff  <= cnt_prev;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.sign_load || cmd.char_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sign_load) begin
         out_char_ff  <= CHAR_MINUS;
         out_final_ff <= 1'b0;
      end else if (cmd.char_load) begin
         out_char_ff  <= row_ff[{dig_ff[2:0], 3'b000} +: CHAR_W];
         out_final_ff <= last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_character  = out_char_ff;
   assign rsp_final_char = out_final_ff;

endmodule
